// File: hw/rtl/dtdc_pkg.sv
// Shared types and constants for the decimal text delta codec.
// No dependencies; used by dtdc_ctrl, dtdc_dpath and the top level.
package dtdc_pkg;

  localparam int unsigned ValW         = 64;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned MaxDigitsDef = 20;

  // Long division by ten handles this many quotient bits per cycle.
  localparam int unsigned DivStepBits  = 8;
  localparam int unsigned NumDivSteps  = ValW / DivStepBits;
  localparam int unsigned StepW        = $clog2(NumDivSteps);
  localparam int unsigned Radix        = 10;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  // Source of the next output byte.
  typedef enum logic [1:0] {
    OSEL_DIGIT = 2'd0,
    OSEL_COMMA = 2'd1,
    OSEL_OPEN  = 2'd2,
    OSEL_CLOSE = 2'd3
  } osel_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic  clear_stream;  // back to stream reset values
    logic  clr_skip;      // first byte seen
    logic  clr_nnw;       // a number has been written
    logic  acc_digit;     // acc = acc*10 + digit
    logic  number_end;    // form difference/sum, start conversion
    logic  conv_step;     // one 8-bit step of division by ten
    logic  digit_pop;     // step down to the next stored digit
    logic  emit_load;     // load the output register
    osel_e emit_sel;
    logic  emit_last;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic is_digit;   // current input byte is '0'..'9'
    logic skip;       // skip_first_byte flag
    logic nnw;        // no_number_written_yet flag
    logic conv_done;  // this conversion step finishes the last digit
    logic cnt_one;    // one stored digit left
    logic cnt_zero;   // no stored digits
    logic out_free;   // output register can take a byte this cycle
  } sts_t;

endpackage

// File: hw/rtl/dtdc_ctrl.sv
// Controller state machine for the decimal text delta codec.
// Depends on dtdc_pkg; drives dtdc_dpath through cmd_t, watches sts_t.
module dtdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mode_i,
  input  logic          in_valid_i,
  input  logic          stream_end_i,
  output logic          in_ready_o,
  input  dtdc_pkg::sts_t sts_i,
  output dtdc_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREFIX = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_DIGITS = 3'd3;
  localparam logic [2:0] S_COMMA  = 3'd4;
  localparam logic [2:0] S_OPEN   = 3'd5;
  localparam logic [2:0] S_CLOSE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_sel = dtdc_pkg::OSEL_DIGIT;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (stream_end_i) begin
            cmd_o.clear_stream = 1'b1;
            if (mode_i) begin
              state_d = sts_i.nnw ? S_OPEN : S_CLOSE;
            end
          end else if (!mode_i && sts_i.skip) begin
            cmd_o.clr_skip = 1'b1;
          end else begin
            cmd_o.clr_skip = 1'b1;
            if (sts_i.is_digit) begin
              cmd_o.acc_digit = 1'b1;
            end else begin
              cmd_o.number_end = 1'b1;
              state_d = mode_i ? S_PREFIX : S_CONV;
            end
          end
        end
      end
      S_PREFIX: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_sel  = sts_i.nnw ? dtdc_pkg::OSEL_OPEN : dtdc_pkg::OSEL_COMMA;
          cmd_o.clr_nnw   = 1'b1;
          state_d         = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_sel  = dtdc_pkg::OSEL_DIGIT;
          cmd_o.emit_last = mode_i && sts_i.cnt_one;
          cmd_o.digit_pop = 1'b1;
          if (sts_i.cnt_one) begin
            state_d = mode_i ? S_IDLE : S_COMMA;
          end
        end
      end
      S_COMMA: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_sel  = dtdc_pkg::OSEL_COMMA;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_OPEN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_sel  = dtdc_pkg::OSEL_OPEN;
          state_d         = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_sel  = dtdc_pkg::OSEL_CLOSE;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Never overwrite a byte the receiver has not taken.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> sts_i.out_free)
    else $error("output loaded while occupied");

  // A digit byte is absorbed without leaving idle.
  a_digit_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !stream_end_i && sts_i.is_digit && !(!mode_i && sts_i.skip))
    |=> state_q == S_IDLE)
    else $error("digit request left idle");

  // Digit emission only with digits in store.
  a_digits_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIGITS |-> !sts_i.cnt_zero)
    else $error("digit emission with empty store");

  // Finished conversion always hands over to emission.
  a_conv_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && sts_i.conv_done) |=> state_q == S_DIGITS)
    else $error("conversion end not followed by emission");

endmodule

// File: hw/rtl/dtdc_dpath.sv
// Datapath for the decimal text delta codec: accumulator, previous value,
// divide-by-ten unit, digit store and output register. Depends on dtdc_pkg.
module dtdc_dpath #(
  parameter int unsigned MAX_DIGITS = dtdc_pkg::MaxDigitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mode_i,
  input  logic [7:0]     in_byte_i,
  input  dtdc_pkg::cmd_t cmd_i,
  output dtdc_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           last_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned VW   = dtdc_pkg::ValW;
  localparam int unsigned DW   = dtdc_pkg::DigitW;
  localparam int unsigned SB   = dtdc_pkg::DivStepBits;

  logic [VW-1:0]   acc_q, prev_q, quo_q;
  logic            skip_q, nnw_q;
  logic [DW-1:0]   rem_q;
  logic [dtdc_pkg::StepW-1:0] step_q;
  logic [CntW-1:0] cnt_q, cnt_m1;
  logic [DW-1:0]   store_q [MAX_DIGITS];
  logic            out_valid_q, last_q;
  logic [7:0]      out_byte_q, byte_d;

  logic [VW-1:0]   acc_x10, sum_w, quo_next;
  logic [DW-1:0]   rem_next, digit_rd;
  logic [SB-1:0]   qbits;
  logic            last_step, is_digit;

  assign is_digit = (in_byte_i >= dtdc_pkg::ChZero) && (in_byte_i <= dtdc_pkg::ChNine);
  // '0'..'9' carry their value in the low nibble
  assign acc_x10  = {acc_q[VW-4:0], 3'b000} + {acc_q[VW-2:0], 1'b0}
                  + VW'(in_byte_i[3:0]);
  assign sum_w    = mode_i ? (acc_q + prev_q) : (acc_q - prev_q);

  // Restoring division by ten, SB quotient bits per cycle, MSB first.
  always_comb begin
    logic [DW:0] t;
    rem_next = rem_q;
    qbits    = '0;
    for (int i = 0; i < SB; i++) begin
      t = {rem_next, quo_q[VW-1-i]};
      if (t >= (DW+1)'(dtdc_pkg::Radix)) begin
        rem_next      = DW'(t - (DW+1)'(dtdc_pkg::Radix));
        qbits[SB-1-i] = 1'b1;
      end else begin
        rem_next = t[DW-1:0];
      end
    end
  end

  assign quo_next  = {quo_q[VW-SB-1:0], qbits};
  assign last_step = (step_q == dtdc_pkg::StepW'(dtdc_pkg::NumDivSteps - 1));
  assign cnt_m1    = cnt_q - 1'b1;
  assign digit_rd  = store_q[cnt_m1[IdxW-1:0]];

  always_comb begin
    case (cmd_i.emit_sel)
      dtdc_pkg::OSEL_DIGIT: byte_d = dtdc_pkg::ChZero + {4'b0000, digit_rd};
      dtdc_pkg::OSEL_COMMA: byte_d = dtdc_pkg::ChComma;
      dtdc_pkg::OSEL_OPEN:  byte_d = dtdc_pkg::ChOpen;
      dtdc_pkg::OSEL_CLOSE: byte_d = dtdc_pkg::ChClose;
      default:              byte_d = dtdc_pkg::ChComma;
    endcase
  end

  assign sts_o.is_digit  = is_digit;
  assign sts_o.skip      = skip_q;
  assign sts_o.nnw       = nnw_q;
  assign sts_o.conv_done = last_step &&
                           ((quo_next == '0) || (cnt_q == CntW'(MAX_DIGITS - 1)));
  assign sts_o.cnt_one   = (cnt_q == CntW'(1));
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // Stream state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      prev_q      <= '0;
      skip_q      <= 1'b1;
      nnw_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_stream) begin
        acc_q  <= '0;
        prev_q <= '0;
        skip_q <= 1'b1;
        nnw_q  <= 1'b1;
      end else begin
        if (cmd_i.clr_skip)   skip_q <= 1'b0;
        if (cmd_i.clr_nnw)    nnw_q  <= 1'b0;
        if (cmd_i.acc_digit)  acc_q  <= acc_x10;
        if (cmd_i.number_end) begin
          acc_q  <= '0;
          prev_q <= mode_i ? sum_w : acc_q;
        end
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Conversion registers and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.number_end) begin
      quo_q  <= sum_w;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.conv_step) begin
      quo_q  <= quo_next;
      step_q <= step_q + 1'b1;
      if (last_step) begin
        store_q[cnt_q[IdxW-1:0]] <= rem_next;
        cnt_q <= cnt_q + 1'b1;
        rem_q <= '0;
      end else begin
        rem_q <= rem_next;
      end
    end else if (cmd_i.digit_pop) begin
      cnt_q <= cnt_m1;
    end
    if (cmd_i.emit_load) begin
      out_byte_q <= byte_d;
      last_q     <= cmd_i.emit_last;
    end
  end

endmodule

// File: hw/rtl/decimal_text_delta_codec_unit.sv
// Top level of the decimal text delta codec: APB mode register, controller
// and datapath. Depends on dtdc_pkg, dtdc_ctrl and dtdc_dpath.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one text byte per
// request, or a stream-end marker when stream_end_i is set. Digits build a
// 64-bit number; any other byte ends it. With mode = 0 (encode) the first
// byte is dropped and each number leaves as its difference to the previous
// one plus a comma; with mode = 1 (decode) each number leaves as the running
// sum, opened by '[' or ','; stream end closes with ']'.
// The output channel (out_valid_o/out_ready_i) carries one byte per request;
// last_o marks the final byte produced by an input request.
// Timing: a digit or dropped byte is absorbed without leaving idle. A number
// end forms the difference or sum; in decode the '[' or ',' byte is then loaded;
// then each decimal digit comes from the shared divide-by-ten unit (8 quotient
// bits per cycle over the 64-bit value, up to MAX_DIGITS digits); then the
// output bytes follow as the receiver takes them. A new request is
// taken as soon as the last byte of the run sits in the output register.
// A stalled receiver holds the output register and with it the controller.
// Reset clears the stream state and selects encode mode; the digit store
// needs no clearing.
module decimal_text_delta_codec_unit #(
  parameter int unsigned MAX_DIGITS = dtdc_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register word index is paddr[2]; only the mode register exists.
  localparam logic RegModeIdx = 1'b0;

  logic           mode_q;
  logic           mode_sel;
  dtdc_pkg::cmd_t cmd;
  dtdc_pkg::sts_t sts;

  assign pready   = 1'b1;
  assign mode_sel = (paddr[2] == RegModeIdx);
  assign prdata   = mode_sel ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && mode_sel) begin
      mode_q <= pwdata[0];
    end
  end

  dtdc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_valid_i),
    .stream_end_i (stream_end_i),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  dtdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_byte_i   (in_byte_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
